FILE: hw/rtl/complex_arithmetic_unit_top_defines.svh
// assertion macros for the complex arithmetic unit
// no dependencies; included by modules that carry assertions
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`ifndef SYNTH
// checked while out of reset, sampled on clk
`define CAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cau assertion failed");
// checked at every edge, reset included
`define CAU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cau assertion failed");
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hw/rtl/cau_pkg.sv
// types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int PART_W = 16;
  localparam int FRAC_W = 12;
  localparam int PROD_W = 2 * PART_W;
  localparam int SUM_W  = 2 * PART_W + 1;
  localparam int DEN_W  = 2 * PART_W;
  localparam int NUM_W  = 2 * PART_W + 2 * FRAC_W;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_RECIP = 3'd4,
    OP_NEG   = 3'd5,
    OP_CONJ  = 3'd6
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [PART_W-1:0] a_real;
    logic signed [PART_W-1:0] a_imag;
    logic signed [PART_W-1:0] b_real;
    logic signed [PART_W-1:0] b_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [PART_W-1:0] res_real;
    logic signed [PART_W-1:0] res_imag;
    logic [1:0]               status;
  } out_item_t;

endpackage

FILE: hw/rtl/complex_arithmetic_unit_top.sv
// throughput: one transfer per cycle while in_stall is low; the divider is a restoring long division
// unrolled one quotient bit per pipeline stage, so every op sees the same latency
// the whole pipe advances together unless a held result is stalled at the output
// reset: rst_n synchronous active low clears all valid bits; data is not reset
// depends on cau_pkg and complex_arithmetic_unit_top_defines.svh
`include "complex_arithmetic_unit_top_defines.svh"

module complex_arithmetic_unit_top
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [SUM_W-1:0]  MAG_MAX = SUM_W'((1 << PART_W) - 1);
  localparam logic [PART_W-1:0] POS_LIM = PART_W'((1 << (PART_W - 1)) - 1);
  localparam logic [PART_W-1:0] NEG_LIM = PART_W'(1 << (PART_W - 1));

  // per stage record of the divider pipe
  typedef struct packed {
    logic              div_op;
    logic              zero;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [PART_W-1:0] byp_re;
    logic [PART_W-1:0] byp_im;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem_re;
    logic [DEN_W-1:0]  rem_im;
    logic [PART_W-1:0] nlo_re;
    logic [PART_W-1:0] nlo_im;
    logic [PART_W-1:0] q_re;
    logic [PART_W-1:0] q_im;
  } dv_t;

  logic advance;

  // whole pipe moves when the output slot is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // stage a: products and divisor squares
  logic                     va_r;
  logic [2:0]               opa_r;
  logic signed [PART_W-1:0] ara_r, aia_r, bra_r, bia_r;
  logic signed [PROD_W-1:0] prr_r, pii_r, pir_r, pri_r, sqr_r, sqi_r;
  logic signed [PART_W-1:0] dre, dim;

  always_comb begin
    dre = (in_data.operation == OP_RECIP) ? in_data.a_real : in_data.b_real;
    dim = (in_data.operation == OP_RECIP) ? in_data.a_imag : in_data.b_imag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (advance) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      opa_r <= in_data.operation;
      ara_r <= in_data.a_real;
      aia_r <= in_data.a_imag;
      bra_r <= in_data.b_real;
      bia_r <= in_data.b_imag;
      prr_r <= in_data.a_real * in_data.b_real;
      pii_r <= in_data.a_imag * in_data.b_imag;
      pir_r <= in_data.a_imag * in_data.b_real;
      pri_r <= in_data.a_real * in_data.b_imag;
      sqr_r <= dre * dre;
      sqi_r <= dim * dim;
    end
  end

  // stage b: exact signed result per op, and the squared magnitude
  logic                    vb_r;
  logic [2:0]              opb_r;
  logic signed [SUM_W-1:0] reb_r, imb_r;
  logic [DEN_W-1:0]        denb_r;
  logic signed [SUM_W-1:0] re_nxt, im_nxt;
  logic signed [SUM_W-1:0] xar, xai, xbr, xbi, xrr, xii, xir, xri;

  always_comb begin
    xar = SUM_W'(ara_r);
    xai = SUM_W'(aia_r);
    xbr = SUM_W'(bra_r);
    xbi = SUM_W'(bia_r);
    xrr = SUM_W'(prr_r);
    xii = SUM_W'(pii_r);
    xir = SUM_W'(pir_r);
    xri = SUM_W'(pri_r);
    re_nxt = '0;
    im_nxt = '0;
    case (opa_r)
      OP_ADD:   begin re_nxt = xar + xbr; im_nxt = xai + xbi; end
      OP_SUB:   begin re_nxt = xar - xbr; im_nxt = xai - xbi; end
      OP_MUL:   begin re_nxt = xrr - xii; im_nxt = xir + xri; end
      OP_DIV:   begin re_nxt = xrr + xii; im_nxt = xir - xri; end
      OP_RECIP: begin re_nxt = xar;       im_nxt = -xai;      end
      OP_NEG:   begin re_nxt = -xar;      im_nxt = -xai;      end
      OP_CONJ:  begin re_nxt = xar;       im_nxt = -xai;      end
      default:  begin re_nxt = '0;        im_nxt = '0;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (advance) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      opb_r  <= opa_r;
      reb_r  <= re_nxt;
      imb_r  <= im_nxt;
      denb_r <= DEN_W'($unsigned(sqr_r)) + DEN_W'($unsigned(sqi_r));
    end
  end

  // stage c: sign and magnitude
  logic              vc_r;
  logic [2:0]        opc_r;
  logic              negc_re_r, negc_im_r;
  logic [SUM_W-1:0]  magc_re_r, magc_im_r;
  logic [DEN_W-1:0]  denc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (advance) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      opc_r     <= opb_r;
      negc_re_r <= reb_r[SUM_W-1];
      negc_im_r <= imb_r[SUM_W-1];
      magc_re_r <= reb_r[SUM_W-1] ? $unsigned(-reb_r) : $unsigned(reb_r);
      magc_im_r <= imb_r[SUM_W-1] ? $unsigned(-imb_r) : $unsigned(imb_r);
      denc_r    <= denb_r;
    end
  end

  // stage d: dividend setup, quotient overflow check, bypass clamp
  logic [NUM_W-1:0] num_re, num_im;
  logic [SUM_W-1:0] sh_re, sh_im;
  logic             is_div;
  dv_t              dv_in;

  always_comb begin
    is_div = (opc_r == OP_DIV) || (opc_r == OP_RECIP);
    if (opc_r == OP_DIV) begin
      num_re = NUM_W'(magc_re_r) << FRAC_W;
      num_im = NUM_W'(magc_im_r) << FRAC_W;
    end else begin
      num_re = NUM_W'(magc_re_r) << (2 * FRAC_W);
      num_im = NUM_W'(magc_im_r) << (2 * FRAC_W);
    end
    // multiply truncates the magnitude, i.e. toward zero
    sh_re = (opc_r == OP_MUL) ? (magc_re_r >> FRAC_W) : magc_re_r;
    sh_im = (opc_r == OP_MUL) ? (magc_im_r >> FRAC_W) : magc_im_r;
    dv_in.div_op = is_div;
    dv_in.zero   = (denc_r == '0);
    dv_in.neg_re = negc_re_r;
    dv_in.neg_im = negc_im_r;
    dv_in.ovf_re = (num_re >> PART_W) >= NUM_W'(denc_r);
    dv_in.ovf_im = (num_im >> PART_W) >= NUM_W'(denc_r);
    dv_in.byp_re = (sh_re > MAG_MAX) ? '1 : sh_re[PART_W-1:0];
    dv_in.byp_im = (sh_im > MAG_MAX) ? '1 : sh_im[PART_W-1:0];
    dv_in.den    = denc_r;
    dv_in.rem_re = num_re[PART_W +: DEN_W];
    dv_in.rem_im = num_im[PART_W +: DEN_W];
    dv_in.nlo_re = num_re[PART_W-1:0];
    dv_in.nlo_im = num_im[PART_W-1:0];
    dv_in.q_re   = '0;
    dv_in.q_im   = '0;
  end

  // divider stages: index 0 is stage d, index k+1 retires quotient bit PART_W-1-k
  dv_t              dv_r  [0:PART_W];
  logic [PART_W:0]  dvv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r <= '0;
    end else if (advance) begin
      dvv_r <= {dvv_r[PART_W-1:0], vc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_r[0] <= dv_in;
    end
  end

  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic bit_in,
                                               input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic [DEN_W:0] d;
    logic           ge;
    t  = {rem, bit_in};
    d  = {1'b0, den};
    ge = (t >= d);
    div_step = ge ? {1'b1, DEN_W'(t - d)} : {1'b0, t[DEN_W-1:0]};
  endfunction

  for (genvar k = 0; k < PART_W; k++) begin : g_div
    localparam int BIT = PART_W - 1 - k;
    logic [DEN_W:0] st_re, st_im;
    dv_t            nxt;

    always_comb begin
      st_re = div_step(dv_r[k].rem_re, dv_r[k].nlo_re[BIT], dv_r[k].den);
      st_im = div_step(dv_r[k].rem_im, dv_r[k].nlo_im[BIT], dv_r[k].den);
      nxt        = dv_r[k];
      nxt.rem_re = st_re[DEN_W-1:0];
      nxt.rem_im = st_im[DEN_W-1:0];
      nxt.q_re   = {dv_r[k].q_re[PART_W-2:0], st_re[DEN_W]};
      nxt.q_im   = {dv_r[k].q_im[PART_W-2:0], st_im[DEN_W]};
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_r[k+1] <= nxt;
      end
    end
  end

  // output stage: pick magnitude, saturate, pack
  dv_t               fin;
  logic [PART_W-1:0] mag_re, mag_im;
  logic              sat_re, sat_im;
  logic [PART_W-1:0] val_re, val_im;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         out_nxt;

  always_comb begin
    fin = dv_r[PART_W];
    if (fin.div_op) begin
      mag_re = fin.ovf_re ? '1 : fin.q_re;
      mag_im = fin.ovf_im ? '1 : fin.q_im;
    end else begin
      mag_re = fin.byp_re;
      mag_im = fin.byp_im;
    end
    if (fin.neg_re) begin
      sat_re = mag_re > NEG_LIM;
      val_re = sat_re ? NEG_LIM : (~mag_re + 1'b1);
    end else begin
      sat_re = mag_re > POS_LIM;
      val_re = sat_re ? POS_LIM : mag_re;
    end
    if (fin.neg_im) begin
      sat_im = mag_im > NEG_LIM;
      val_im = sat_im ? NEG_LIM : (~mag_im + 1'b1);
    end else begin
      sat_im = mag_im > POS_LIM;
      val_im = sat_im ? POS_LIM : mag_im;
    end
    if (fin.div_op && fin.zero) begin
      out_nxt.res_real = '0;
      out_nxt.res_imag = '0;
      out_nxt.status   = ST_DIV0;
    end else begin
      out_nxt.res_real = $signed(val_re);
      out_nxt.res_imag = $signed(val_im);
      out_nxt.status   = (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= dvv_r[PART_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // both parts of a result are zero
  function automatic logic parts_zero(out_item_t o);
    return o.res_real == '0 && o.res_imag == '0;
  endfunction

  // at least one part sits at a limit
  function automatic logic part_pinned(out_item_t o);
    return o.res_real == POS_LIM || o.res_real == NEG_LIM ||
           o.res_imag == POS_LIM || o.res_imag == NEG_LIM;
  endfunction

  // a divide by zero result carries zero parts
  `CAU_ASSERT(a_div0_zero, out_valid_r && out_data_r.status == ST_DIV0 |-> parts_zero(out_data_r))
  // a saturated result has at least one part pinned at a limit
  `CAU_ASSERT(a_sat_limit, out_valid_r && out_data_r.status == ST_SAT |-> part_pinned(out_data_r))
  // an accepted item is in stage a on the next edge
  `CAU_ASSERT(a_enter, in_valid && !in_stall |=> va_r)
  // reset empties the output slot
  `CAU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r)

endmodule

FILE: test/tb_complex_arithmetic_unit_top.sv
// self-checking testbench for the complex arithmetic unit top level
// depends on cau_pkg and complex_arithmetic_unit_top; predicts results in fixed point itself
module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;

  localparam int IDLE_LIMIT = 3000;   // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 40;   // covers the pipeline latency
  localparam logic [2:0] OP_CODE_UNUSED = 3'd7;   // gives a zero result

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t result_fifo[$];   // predicted results, oldest first
  int        error_count = 0;
  int        burst_left = 0;
  int        hold_left = 0;    // long receiver hold-off, set by the pressure test
  int        idle_cycles = 0;

  complex_arithmetic_unit_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // truncate toward zero after a right shift
  function automatic longint shift_trunc(longint v, int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  // (num << sh) / den, rounded toward zero
  function automatic longint div_trunc(longint num, int sh, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag << sh) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // clamp to the part range and flag saturation
  function automatic logic signed [PART_W-1:0] clamp_part(longint v, inout bit sat);
    longint hi, lo;
    hi = (longint'(1) <<< (PART_W - 1)) - 1;
    lo = -(longint'(1) <<< (PART_W - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[PART_W-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[PART_W-1:0];
    end
    return v[PART_W-1:0];
  endfunction

  function automatic out_item_t complex_result(in_item_t it);
    out_item_t r;
    longint ar, ai, br, bi, re, im, den;
    bit sat;
    ar = longint'(it.a_real);
    ai = longint'(it.a_imag);
    br = longint'(it.b_real);
    bi = longint'(it.b_imag);
    re = 0;
    im = 0;
    sat = 1'b0;
    case (it.operation)
      OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      OP_MUL: begin
        re = shift_trunc(ar * br - ai * bi, FRAC_W);
        im = shift_trunc(ai * br + ar * bi, FRAC_W);
      end
      OP_DIV, OP_RECIP: begin
        den = (it.operation == OP_DIV) ? br * br + bi * bi : ar * ar + ai * ai;
        if (den == 0) begin
          r.res_real = '0;
          r.res_imag = '0;
          r.status = ST_DIV0;
          return r;
        end
        if (it.operation == OP_DIV) begin
          re = div_trunc(ar * br + ai * bi, FRAC_W, den);
          im = div_trunc(ai * br - ar * bi, FRAC_W, den);
        end else begin
          re = div_trunc(ar, 2 * FRAC_W, den);
          im = div_trunc(-ai, 2 * FRAC_W, den);
        end
      end
      OP_NEG: begin
        re = -ar;
        im = -ai;
      end
      OP_CONJ: begin
        re = ar;
        im = -ai;
      end
      default: ;  // unused code gives zero
    endcase
    r.res_real = clamp_part(re, sat);
    r.res_imag = clamp_part(im, sat);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // send one item, wait for its transfer, then maybe idle between bursts
  task automatic send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_fifo.push_back(complex_result(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(0, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_op(logic [2:0] op, int ar, int ai, int br, int bi);
    in_item_t it;
    it.operation = op;
    it.a_real = ar[PART_W-1:0];
    it.a_imag = ai[PART_W-1:0];
    it.b_real = br[PART_W-1:0];
    it.b_imag = bi[PART_W-1:0];
    send_item(it);
  endtask

  // random part: full range, extremes, moderate values near unity, or small values near zero
  function automatic logic [PART_W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 16'h3fff)) - 16'sh2000);
      3: return 16'($signed($urandom_range(0, 64)) - 16'sd32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation = ($urandom_range(0, 40) == 0) ? OP_CODE_UNUSED : 3'($urandom_range(0, 6));
    it.a_real = rand_part();
    it.a_imag = rand_part();
    it.b_real = rand_part();
    it.b_imag = rand_part();
    // zero divisors now and then
    if ($urandom_range(0, 15) == 0) begin
      if (it.operation == OP_RECIP) begin
        it.a_real = '0;
        it.a_imag = '0;
      end else begin
        it.b_real = '0;
        it.b_imag = '0;
      end
    end
    return it;
  endfunction

  task automatic test_directed();
    send_op(OP_ADD, 32767, -32768, 32767, -32768);   // both parts saturate
    send_op(OP_ADD, 4096, -4096, 8192, 1);
    send_op(OP_SUB, -32768, 32767, 1, -1);
    send_op(OP_SUB, 100, 200, 100, 200);
    send_op(OP_MUL, 4096, 0, 4096, 0);               // 1 * 1
    send_op(OP_MUL, -32768, -32768, -32768, 32767);
    send_op(OP_MUL, -1, 1, 1, 1);                    // truncation toward zero
    send_op(OP_DIV, 4096, 4096, 4096, 0);
    send_op(OP_DIV, 1, 2, 0, 0);                     // divide by zero
    send_op(OP_DIV, 32767, -32768, 1, 0);            // huge quotient saturates
    send_op(OP_DIV, -32768, -32768, -32768, -32768);
    send_op(OP_DIV, 3, -7, 32767, 32767);
    send_op(OP_RECIP, 0, 0, 5, 5);                   // reciprocal of zero
    send_op(OP_RECIP, 4096, 0, 0, 0);
    send_op(OP_RECIP, -32768, 32767, 0, 0);
    send_op(OP_RECIP, 1, -1, 0, 0);
    send_op(OP_NEG, -32768, -32768, 0, 0);           // negating most negative
    send_op(OP_NEG, 32767, 1, -1, -1);
    send_op(OP_CONJ, -32768, -32768, 0, 0);
    send_op(OP_CONJ, 12345, -12345, 0, 0);
    send_op(OP_CODE_UNUSED, 32767, -32768, 32767, -32768);
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(rand_item());
  endtask

  // receiver holds off for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    hold_left = 300;
    burst_left = 80;
    repeat (80) send_item(rand_item());
  endtask

  // receiver stall pattern, in one of four randomly chosen modes unless a hold-off runs
  int stall_mode = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (stall_tick % 4 == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_fifo.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = result_fifo.pop_front();
        if (out_data.res_real !== want.res_real)
          report_mismatch("res_real", out_data.res_real, want.res_real);
        if (out_data.res_imag !== want.res_imag)
          report_mismatch("res_imag", out_data.res_imag, want.res_imag);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(325);
    test_backpressure();
    test_random(325);
    in_valid <= 1'b0;
    while (result_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
